FILE: design/pira_pkg.sv
`default_nettype none

package pira_pkg;

    localparam int MODE_W  = 3;
    localparam int POS_W   = 7;
    localparam int WORD_W  = 32;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 7;

    // request kinds
    localparam logic [MODE_W-1:0] MODE_INSERT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 3'd4;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_UNDER = 2'd2;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SHIFT = 4'b0010,
        ST_FILL  = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

endpackage

`default_nettype wire

FILE: design/positional_insert_remove_array.sv
// Positional insert/remove array: an ordered store of up to CAPACITY signed
// 32-bit words plus its element count.
// Input channel (s_valid/s_ready): one request beat carries s_mode (insert,
// push, remove, pop, lookup), s_position and s_item_value.
// Result channel (m_valid/m_ready): exactly one beat per request with the word
// read (zero unless a remove, pop or lookup succeeds), a status code and the
// element count after the request (low 7 bits of the count).
// Insert and remove walk the entries from the position to the end of the
// store; push and any rejected request go straight to the result. The walk is
// set by the word memory (one read port, one write port): shifting moves one
// entry per cycle through a registered read and one write.
// One request is in flight at a time; s_ready is high only while idle.
// The result sits in an output register, so the next request is accepted while
// a result still waits; a stalled receiver only blocks the end of the
// following request until its result can be loaded.
// Reset (aresetn, synchronous, active low) empties the store: count goes to
// zero. Memory contents are not cleared; only entries below the count are read.
`default_nettype none

module positional_insert_remove_array #(
    parameter int CAPACITY = 64
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,

    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [pira_pkg::MODE_W-1:0]         s_mode,
    input  wire logic [pira_pkg::POS_W-1:0]          s_position,
    input  wire logic signed [pira_pkg::WORD_W-1:0]  s_item_value,

    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed [pira_pkg::WORD_W-1:0]       m_read_value,
    output logic [pira_pkg::STAT_W-1:0]              m_status,
    output logic [pira_pkg::COUNT_W-1:0]             m_element_count
);

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    // common width for position/count compares
    localparam int CMP_W  = (CNT_W > pira_pkg::POS_W) ? CNT_W : pira_pkg::POS_W;

    // word storage, registered read
    logic [pira_pkg::WORD_W-1:0] mem [CAPACITY];
    logic [pira_pkg::WORD_W-1:0] mem_rdata_reg;
    logic                        mem_we;
    logic [ADDR_W-1:0]           mem_waddr;
    logic [pira_pkg::WORD_W-1:0] mem_wdata;
    logic                        mem_re;
    logic [ADDR_W-1:0]           mem_raddr;

    pira_pkg::state_t            state_reg, state_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic [ADDR_W-1:0]           addr_reg, addr_next;   // address of last issued read
    logic [ADDR_W-1:0]           last_reg, last_next;   // final read address of the walk
    logic                        up_reg, up_next;       // 1: shift up (insert)
    logic                        first_reg, first_next; // next read data is the result word
    logic [pira_pkg::WORD_W-1:0] val_reg, val_next;
    logic [pira_pkg::WORD_W-1:0] word_reg, word_next;
    logic [pira_pkg::STAT_W-1:0] status_reg, status_next;

    logic                        m_valid_reg, m_valid_next;
    logic [pira_pkg::WORD_W-1:0] m_read_value_reg, m_read_value_next;
    logic [pira_pkg::STAT_W-1:0] m_status_reg, m_status_next;
    logic [pira_pkg::COUNT_W-1:0] m_count_reg, m_count_next;

    // request decode helpers
    logic [CMP_W-1:0]  pos_ext, cnt_ext, cap_ext, ins_ext, rem_ext, after_ext;
    logic [CNT_W-1:0]  cnt_m1;
    logic              full, empty;

    assign pos_ext   = CMP_W'(s_position);
    assign cnt_ext   = CMP_W'(count_reg);
    assign cap_ext   = CMP_W'(CAPACITY);
    assign cnt_m1    = count_reg - CNT_W'(1);
    assign full      = (cnt_ext == cap_ext);
    assign empty     = (count_reg == '0);
    assign ins_ext   = (s_mode == pira_pkg::MODE_PUSH) ? cnt_ext : pos_ext;
    assign rem_ext   = (s_mode == pira_pkg::MODE_POP) ? CMP_W'(cnt_m1) : pos_ext;
    assign after_ext = CMP_W'(count_reg);

    always_comb begin
        state_next        = state_reg;
        count_next        = count_reg;
        addr_next         = addr_reg;
        last_next         = last_reg;
        up_next           = up_reg;
        first_next        = first_reg;
        val_next          = val_reg;
        word_next         = word_reg;
        status_next       = status_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_read_value_next = m_read_value_reg;
        m_status_next     = m_status_reg;
        m_count_next      = m_count_reg;
        mem_we            = 1'b0;
        mem_waddr         = '0;
        mem_wdata         = '0;
        mem_re            = 1'b0;
        mem_raddr         = '0;

        case (state_reg)
            pira_pkg::ST_IDLE: begin
                if (s_valid) begin
                    val_next    = s_item_value;
                    word_next   = '0;
                    status_next = pira_pkg::STAT_OK;
                    first_next  = 1'b0;
                    up_next     = 1'b0;
                    state_next  = pira_pkg::ST_DONE;
                    case (s_mode)
                        pira_pkg::MODE_INSERT, pira_pkg::MODE_PUSH: begin
                            if (ins_ext > cnt_ext) begin
                                status_next = pira_pkg::STAT_RANGE;
                            end else if (full) begin
                                status_next = pira_pkg::STAT_FULL;
                            end else begin
                                count_next = count_reg + CNT_W'(1);
                                if (ins_ext == cnt_ext) begin
                                    // append: no shift needed
                                    mem_we    = 1'b1;
                                    mem_waddr = ins_ext[ADDR_W-1:0];
                                    mem_wdata = s_item_value;
                                end else begin
                                    // walk down from the top entry
                                    mem_re     = 1'b1;
                                    mem_raddr  = cnt_m1[ADDR_W-1:0];
                                    addr_next  = cnt_m1[ADDR_W-1:0];
                                    last_next  = ins_ext[ADDR_W-1:0];
                                    up_next    = 1'b1;
                                    state_next = pira_pkg::ST_SHIFT;
                                end
                            end
                        end
                        pira_pkg::MODE_REMOVE, pira_pkg::MODE_POP: begin
                            if (s_mode == pira_pkg::MODE_POP && empty) begin
                                status_next = pira_pkg::STAT_UNDER;
                            end else if (rem_ext >= cnt_ext) begin
                                status_next = pira_pkg::STAT_RANGE;
                            end else begin
                                count_next = cnt_m1;
                                mem_re     = 1'b1;
                                mem_raddr  = rem_ext[ADDR_W-1:0];
                                addr_next  = rem_ext[ADDR_W-1:0];
                                last_next  = cnt_m1[ADDR_W-1:0];
                                first_next = 1'b1;
                                state_next = pira_pkg::ST_SHIFT;
                            end
                        end
                        pira_pkg::MODE_LOOKUP: begin
                            if (pos_ext >= cnt_ext) begin
                                status_next = pira_pkg::STAT_RANGE;
                            end else begin
                                // a one-entry walk with no writes
                                mem_re     = 1'b1;
                                mem_raddr  = pos_ext[ADDR_W-1:0];
                                addr_next  = pos_ext[ADDR_W-1:0];
                                last_next  = pos_ext[ADDR_W-1:0];
                                first_next = 1'b1;
                                state_next = pira_pkg::ST_SHIFT;
                            end
                        end
                        default: begin
                            status_next = pira_pkg::STAT_OK;
                        end
                    endcase
                end
            end
            pira_pkg::ST_SHIFT: begin
                // data for addr_reg is in mem_rdata_reg this cycle
                if (up_reg) begin
                    mem_we    = 1'b1;
                    mem_waddr = addr_reg + ADDR_W'(1);
                    mem_wdata = mem_rdata_reg;
                end else if (first_reg) begin
                    word_next  = mem_rdata_reg;
                    first_next = 1'b0;
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = addr_reg - ADDR_W'(1);
                    mem_wdata = mem_rdata_reg;
                end
                if (addr_reg != last_reg) begin
                    mem_re    = 1'b1;
                    mem_raddr = up_reg ? (addr_reg - ADDR_W'(1)) : (addr_reg + ADDR_W'(1));
                    addr_next = mem_raddr;
                end else begin
                    state_next = up_reg ? pira_pkg::ST_FILL : pira_pkg::ST_DONE;
                end
            end
            pira_pkg::ST_FILL: begin
                mem_we     = 1'b1;
                mem_waddr  = last_reg;
                mem_wdata  = val_reg;
                state_next = pira_pkg::ST_DONE;
            end
            pira_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next      = 1'b1;
                    m_read_value_next = word_reg;
                    m_status_next     = status_reg;
                    m_count_next      = after_ext[pira_pkg::COUNT_W-1:0];
                    state_next        = pira_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pira_pkg::ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= pira_pkg::ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload and walk registers
    always_ff @(posedge aclk) begin
        addr_reg         <= addr_next;
        last_reg         <= last_next;
        up_reg           <= up_next;
        first_reg        <= first_next;
        val_reg          <= val_next;
        word_reg         <= word_next;
        status_reg       <= status_next;
        m_read_value_reg <= m_read_value_next;
        m_status_reg     <= m_status_next;
        m_count_reg      <= m_count_next;
    end

    // word memory
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            mem_rdata_reg <= mem[mem_raddr];
        end
    end

    assign s_ready         = (state_reg == pira_pkg::ST_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_read_value    = m_read_value_reg;
    assign m_status        = m_status_reg;
    assign m_element_count = m_count_reg;

    // count stays within capacity
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        CMP_W'(count_reg) <= cap_ext)
        else $error("element count above capacity");

    // a shift never reads and writes the same entry in one cycle
    a_no_rw_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("read and write to the same entry");

    // walk address never passes its end point
    a_walk_dir: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == pira_pkg::ST_SHIFT) |->
            (up_reg ? (addr_reg >= last_reg) : (addr_reg <= last_reg)))
        else $error("walk address passed its end");

    // a result is loaded only from the done state
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == pira_pkg::ST_DONE))
        else $error("result loaded outside done state");

endmodule

`default_nettype wire

FILE: sim/positional_insert_remove_array_tb.sv
`default_nettype none

module positional_insert_remove_array_tb;

    localparam int DEPTH = 64;
    // tail after the last expected beat: long enough for a stray late beat to
    // show up after the longest shift
    localparam int TAIL_CYCLES = DEPTH + 16;
    localparam int RANDOM_ITEMS = 700;
    localparam int MAX_PRINTS = 200;

    typedef logic [pira_pkg::MODE_W-1:0]         mode_t;
    typedef logic [pira_pkg::POS_W-1:0]          pos_t;
    typedef logic signed [pira_pkg::WORD_W-1:0]  word_t;
    typedef logic [pira_pkg::STAT_W-1:0]         stat_t;
    typedef logic [pira_pkg::COUNT_W-1:0]        count_t;

    // modes above lookup are reserved and must behave as no-ops
    localparam mode_t MODE_RESERVED = pira_pkg::MODE_LOOKUP + 3'd1;

    // one request beat; a hold entry is a marker that makes the driver wait
    // until every outstanding result has come back
    typedef struct {
        bit       hold;
        mode_t    mode;
        pos_t     pos;
        word_t    value;
    } array_req_t;

    // one result beat
    typedef struct {
        word_t    word;
        stat_t    status;
        count_t   count;
    } array_rsp_t;

    typedef enum {SEG_GROW, SEG_SHRINK, SEG_MIX} seg_kind_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    mode_t      s_mode = pira_pkg::MODE_INSERT;
    pos_t       s_position = '0;
    word_t      s_item_value = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    word_t      m_read_value;
    stat_t      m_status;
    count_t     m_element_count;

    positional_insert_remove_array #(
        .CAPACITY(DEPTH)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_mode(s_mode),
        .s_position(s_position),
        .s_item_value(s_item_value),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_read_value(m_read_value),
        .m_status(m_status),
        .m_element_count(m_element_count)
    );

    always #10 aclk = ~aclk;

    // ---------------------------------------------------------------------
    // Shadow copy of the array, updated when a request beat is accepted.
    // ---------------------------------------------------------------------
    word_t                      shadow_words [DEPTH];
    int                         shadow_count = 0;

    array_req_t                 pending_reqs [$];
    array_rsp_t                 expected_rsps [$];
    int                         n_errors = 0;
    int                         plan_count = 0;   // count as seen by the stimulus planner

    task automatic report_mismatch(string msg);
        if (n_errors < MAX_PRINTS)
            $display("MISMATCH @%0t: %s", $realtime, msg);
        n_errors++;
    endtask

    // open a hole at 'at' and store the word there
    function automatic stat_t shift_in(int at, word_t word);
        if (at > shadow_count)
            return pira_pkg::STAT_RANGE;
        if (shadow_count >= DEPTH)
            return pira_pkg::STAT_FULL;
        for (int i = shadow_count; i > at; i--)
            shadow_words[i] = shadow_words[i - 1];
        shadow_words[at] = word;
        shadow_count++;
        return pira_pkg::STAT_OK;
    endfunction

    // take the word at 'at' out and close the gap
    function automatic stat_t shift_out(int at, output word_t word);
        word = '0;
        if (at >= shadow_count)
            return pira_pkg::STAT_RANGE;
        word = shadow_words[at];
        for (int i = at; i + 1 < shadow_count; i++)
            shadow_words[i] = shadow_words[i + 1];
        shadow_count--;
        return pira_pkg::STAT_OK;
    endfunction

    function automatic array_rsp_t apply_request(array_req_t r);
        array_rsp_t res;
        res.word = '0;
        res.status = pira_pkg::STAT_OK;
        case (r.mode)
            pira_pkg::MODE_INSERT: res.status = shift_in(int'(r.pos), r.value);
            pira_pkg::MODE_PUSH:   res.status = shift_in(shadow_count, r.value);
            pira_pkg::MODE_REMOVE: res.status = shift_out(int'(r.pos), res.word);
            pira_pkg::MODE_POP: begin
                if (shadow_count == 0)
                    res.status = pira_pkg::STAT_UNDER;
                else
                    res.status = shift_out(shadow_count - 1, res.word);
            end
            pira_pkg::MODE_LOOKUP: begin
                if (int'(r.pos) < shadow_count)
                    res.word = shadow_words[r.pos];
                else
                    res.status = pira_pkg::STAT_RANGE;
            end
            default: ;  // reserved modes leave everything alone
        endcase
        res.count = count_t'(shadow_count);
        return res;
    endfunction

    // ---------------------------------------------------------------------
    // Stimulus planning helpers
    // ---------------------------------------------------------------------
    // count after a request, tracked only to steer positions and phases
    function automatic int count_after(array_req_t r, int cnt);
        case (r.mode)
            pira_pkg::MODE_INSERT: return (int'(r.pos) <= cnt && cnt < DEPTH) ? cnt + 1 : cnt;
            pira_pkg::MODE_PUSH:   return (cnt < DEPTH) ? cnt + 1 : cnt;
            pira_pkg::MODE_REMOVE: return (int'(r.pos) < cnt) ? cnt - 1 : cnt;
            pira_pkg::MODE_POP:    return (cnt > 0) ? cnt - 1 : cnt;
            default:               return cnt;
        endcase
    endfunction

    // mostly a legal index up to 'limit', sometimes just past it, sometimes anywhere
    function automatic pos_t pick_pos(int limit);
        int w;
        int hi;
        w = $urandom_range(0, 99);
        hi = (limit < 0) ? 0 : limit;
        if (w < 80)
            return pos_t'($urandom_range(0, hi));
        if (w < 90) begin
            hi = limit + 1 + $urandom_range(0, 2);
            return pos_t'((hi > 127) ? 127 : hi);
        end
        return pos_t'($urandom_range(0, 127));
    endfunction

    function automatic word_t pick_word();
        case ($urandom_range(0, 19))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3:       return -32'sd1;
            default: return $urandom();
        endcase
    endfunction

    task automatic queue_req(mode_t mode, pos_t pos, word_t value);
        array_req_t r;
        r.hold = 1'b0;
        r.mode = mode;
        r.pos = pos;
        r.value = value;
        pending_reqs.push_back(r);
        plan_count = count_after(r, plan_count);
    endtask

    task automatic queue_hold();
        array_req_t r;
        r.hold = 1'b1;
        r.mode = pira_pkg::MODE_INSERT;
        r.pos = '0;
        r.value = '0;
        pending_reqs.push_back(r);
    endtask

    // a run of requests weighted to grow, shrink or churn the array
    task automatic queue_segment(seg_kind_t kind, int len);
        int w;
        mode_t mode;
        pos_t pos;
        for (int k = 0; k < len; k++) begin
            w = $urandom_range(0, 99);
            case (kind)
                SEG_GROW:
                    mode = (w < 45) ? pira_pkg::MODE_INSERT :
                           (w < 85) ? pira_pkg::MODE_PUSH :
                           (w < 92) ? pira_pkg::MODE_LOOKUP :
                           (w < 97) ? pira_pkg::MODE_REMOVE : pira_pkg::MODE_POP;
                SEG_SHRINK:
                    mode = (w < 40) ? pira_pkg::MODE_REMOVE :
                           (w < 75) ? pira_pkg::MODE_POP :
                           (w < 85) ? pira_pkg::MODE_LOOKUP :
                           (w < 95) ? pira_pkg::MODE_INSERT : pira_pkg::MODE_PUSH;
                default:
                    mode = (w < 20) ? pira_pkg::MODE_INSERT :
                           (w < 40) ? pira_pkg::MODE_PUSH :
                           (w < 60) ? pira_pkg::MODE_REMOVE :
                           (w < 77) ? pira_pkg::MODE_POP :
                           (w < 96) ? pira_pkg::MODE_LOOKUP :
                           MODE_RESERVED + mode_t'($urandom_range(0, 2));
            endcase
            case (mode)
                pira_pkg::MODE_INSERT:
                    pos = pick_pos(plan_count);
                pira_pkg::MODE_REMOVE, pira_pkg::MODE_LOOKUP:
                    pos = pick_pos(plan_count - 1);
                default:
                    pos = pos_t'($urandom_range(0, 127));
            endcase
            queue_req(mode, pos, pick_word());
        end
    endtask

    function automatic int draw_idle(bit steady);
        int w;
        if (steady)
            return 0;
        w = $urandom_range(0, 99);
        if (w < 60) return 0;
        if (w < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ---------------------------------------------------------------------
    // Driver: presents queued requests with random idle gaps between beats.
    // Valid stays up with a stable payload until the beat is taken.
    // ---------------------------------------------------------------------
    array_req_t tx_req;
    bit         tx_busy;
    int         tx_idle = 0;
    bit         tx_steady = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_mode <= pira_pkg::MODE_INSERT;
            s_position <= '0;
            s_item_value <= '0;
            tx_idle = 0;
        end else begin
            tx_busy = s_valid;
            if (s_valid && s_ready) begin
                // beat taken: predict its result now, the block holds one at a time
                expected_rsps.push_back(apply_request(tx_req));
                tx_busy = 1'b0;
                if ($urandom_range(0, 39) == 0)
                    tx_steady = !tx_steady;   // switch between bursts and gappy traffic
                tx_idle = draw_idle(tx_steady);
            end
            if (!tx_busy) begin
                if (tx_idle > 0) begin
                    tx_idle--;
                end else if (pending_reqs.size() > 0) begin
                    if (pending_reqs[0].hold) begin
                        // drain point: hold off until every result is back
                        if (expected_rsps.size() == 0)
                            void'(pending_reqs.pop_front());
                    end else begin
                        tx_req = pending_reqs.pop_front();
                        s_mode <= tx_req.mode;
                        s_position <= tx_req.pos;
                        s_item_value <= tx_req.value;
                        tx_busy = 1'b1;
                    end
                end
            end
            s_valid <= tx_busy;   // single update per edge
        end
    end

    // ---------------------------------------------------------------------
    // Monitor: random backpressure on the result side, every taken beat is
    // compared field by field with the oldest prediction.
    // ---------------------------------------------------------------------
    array_rsp_t want;
    bit         rx_take;
    int         rx_idle = 0;
    bit         rx_steady = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_idle = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_rsps.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat: value %0d status %0d count %0d",
                                              m_read_value, m_status, m_element_count));
                end else begin
                    want = expected_rsps.pop_front();
                    if (m_read_value !== want.word)
                        report_mismatch($sformatf("read_value %0d, want %0d",
                                                  m_read_value, want.word));
                    if (m_status !== want.status)
                        report_mismatch($sformatf("status %0d, want %0d",
                                                  m_status, want.status));
                    if (m_element_count !== want.count)
                        report_mismatch($sformatf("element_count %0d, want %0d",
                                                  m_element_count, want.count));
                end
                if ($urandom_range(0, 39) == 0)
                    rx_steady = !rx_steady;
            end
            if (rx_idle > 0) begin
                rx_idle--;
                rx_take = 1'b0;
            end else begin
                rx_take = 1'b1;
                if ($urandom_range(0, 3) == 0)
                    rx_idle = draw_idle(rx_steady);
            end
            m_ready <= rx_take;
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus and end of run
    // ---------------------------------------------------------------------
    int         n_planned;
    int         seg_len;
    seg_kind_t  seg;

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // corner cases on an empty array
        queue_req(pira_pkg::MODE_POP, 7'd0, 32'sd0);               // underflow
        queue_req(pira_pkg::MODE_REMOVE, 7'd0, 32'sd0);            // nothing to remove
        queue_req(pira_pkg::MODE_LOOKUP, 7'd0, 32'sd0);            // nothing to read
        queue_req(pira_pkg::MODE_INSERT, 7'd1, 32'sd1);            // past the end
        // reserved modes: no-op, status ok
        queue_req(MODE_RESERVED, 7'd127, -32'sd1);
        queue_req(MODE_RESERVED + 3'd1, 7'd0, 32'sh7FFF_FFFF);
        queue_req(MODE_RESERVED + 3'd2, 7'd64, 32'sh8000_0000);
        // build [-1, 0, max, min, 0x55555555] with value extremes
        queue_req(pira_pkg::MODE_PUSH, 7'd127, 32'sh7FFF_FFFF);
        queue_req(pira_pkg::MODE_PUSH, 7'd0, 32'sh8000_0000);
        queue_req(pira_pkg::MODE_INSERT, 7'd0, -32'sd1);           // at the front
        queue_req(pira_pkg::MODE_INSERT, 7'd1, 32'sd0);            // in the middle
        queue_req(pira_pkg::MODE_INSERT, 7'd4, 32'sh5555_5555);    // exactly at the end
        queue_req(pira_pkg::MODE_INSERT, 7'd127, 32'shAAAA_AAAA);  // far past the end
        queue_req(pira_pkg::MODE_LOOKUP, 7'd0, 32'sd0);
        queue_req(pira_pkg::MODE_LOOKUP, 7'd4, 32'sd0);
        queue_req(pira_pkg::MODE_LOOKUP, 7'd5, 32'sd0);            // one past the last
        queue_req(pira_pkg::MODE_LOOKUP, 7'd127, 32'sd0);
        queue_req(pira_pkg::MODE_REMOVE, 7'd1, 32'sd0);            // middle
        queue_req(pira_pkg::MODE_REMOVE, 7'd3, 32'sd0);            // last
        queue_req(pira_pkg::MODE_REMOVE, 7'd3, 32'sd0);            // now past the end
        queue_req(pira_pkg::MODE_REMOVE, 7'd127, 32'sd0);
        repeat (4) queue_req(pira_pkg::MODE_POP, 7'd0, 32'sd0);    // empty it, then underflow

        // random phases; the first one fills the array and pounds on the full case
        n_planned = 0;
        while (n_planned < RANDOM_ITEMS) begin
            if (n_planned == 0) begin
                queue_hold();
                queue_segment(SEG_GROW, 90);
                n_planned += 90;
            end else begin
                if ($urandom_range(0, 2) == 0)
                    queue_hold();
                case ($urandom_range(0, 2))
                    0:       seg = SEG_GROW;
                    1:       seg = SEG_SHRINK;
                    default: seg = SEG_MIX;
                endcase
                // grow harder when the array is small, shrink when it is big
                if (plan_count < 8 && seg == SEG_SHRINK)
                    seg = SEG_MIX;
                if (plan_count > DEPTH - 8 && $urandom_range(0, 1) == 0)
                    seg = SEG_SHRINK;
                seg_len = 30 + $urandom_range(0, 60);
                queue_segment(seg, seg_len);
                n_planned = n_planned + seg_len;
            end
        end

        while (pending_reqs.size() > 0 || s_valid || expected_rsps.size() > 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (n_errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // watchdog: several times the slowest legal run
    initial begin
        #12_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
